>>> design/sdt_pkg.sv
// ----------------------------------------------------------------------------
// sdt_pkg: shared types and constants of the seen-device table
// Table geometry, field widths, action and register codes, and the token
// and write-command records that travel along the chain of table cells.
// ----------------------------------------------------------------------------
package sdt_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Field widths
  localparam int ADDR_W     = 48;
  localparam int DBM_W      = 8;
  localparam int TIME_W     = 32;
  localparam int SLOT_W     = 5;
  localparam int ACTION_W   = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Result action codes
  localparam logic [ACTION_W-1:0] ACT_SKIP    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_REFRESH = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REWRITE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_NEW     = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_EVICT   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOVER     = 4'd1;

  // Configuration reset values
  localparam logic [TIME_W-1:0] MIN_INTERVAL_RST = 32'd1000;
  localparam logic              DISCOVER_RST     = 1'b1;

  // Search token: the lookup key plus what the search has found so far
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              have_free;
    logic [IDX_W-1:0]  free_slot;
    logic              have_old;
    logic [TIME_W-1:0] old_time;
    logic [IDX_W-1:0]  old_slot;
    logic              have_match;
    logic [IDX_W-1:0]  match_slot;
    logic [TIME_W-1:0] match_wtime;
  } token_t;

  // Write command broadcast to all cells at the end of an item
  typedef struct packed {
    logic                    en;
    logic                    full;
    logic [IDX_W-1:0]        slot;
    logic [ADDR_W-1:0]       addr;
    logic signed [DBM_W-1:0] sig;
    logic signed [DBM_W-1:0] pwr;
    logic [TIME_W-1:0]       now;
    logic                    tgt;
  } wr_cmd_t;

endpackage

>>> design/sdt_if.sv
// ----------------------------------------------------------------------------
// sdt_if: channel interfaces of the seen-device table
// Advertisement input, result output and configuration write channels,
// each a valid/ready channel with source and sink modports.
// ----------------------------------------------------------------------------
interface sdt_adv_if import sdt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ADDR_W-1:0]       device_addr;
  logic signed [DBM_W-1:0] signal_dbm;
  logic signed [DBM_W-1:0] ref_power_dbm;
  logic [TIME_W-1:0]       time_ms;
  logic                    target_flag;

  modport source (output valid, device_addr, signal_dbm, ref_power_dbm, time_ms,
                  target_flag, input ready);
  modport sink   (input valid, device_addr, signal_dbm, ref_power_dbm, time_ms,
                  target_flag, output ready);
endinterface

interface sdt_res_if import sdt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot_index;
  logic [ACTION_W-1:0] action;

  modport source (output valid, slot_index, action, input ready);
  modport sink   (input valid, slot_index, action, output ready);
endinterface

interface sdt_cfg_if import sdt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/sdt_cell.sv
// ----------------------------------------------------------------------------
// sdt_cell: one entry of the seen-device table
// Holds one entry, folds it into the passing search token and registers
// the token for the next cell. Applies the broadcast write command when
// it addresses this cell.
// ----------------------------------------------------------------------------
module sdt_cell import sdt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  logic             tok_vld_i,
  input  token_t           tok_i,
  output logic             tok_vld_o,
  output token_t           tok_o,
  input  wr_cmd_t          wr_i
);

  // Entry storage
  logic                    valid_q;
  logic [ADDR_W-1:0]       addr_q;
  logic signed [DBM_W-1:0] sig_q;
  logic signed [DBM_W-1:0] pwr_q;
  logic [TIME_W-1:0]       seen_q;
  logic [TIME_W-1:0]       wtime_q;
  logic                    tgt_q;

  logic   tok_vld_q;
  token_t tok_q, tok_d;
  logic   hit;

  assign hit = wr_i.en && (wr_i.slot == idx_i);

  // Fold this entry into the token; nothing changes once a match is found
  always_comb begin
    tok_d = tok_i;
    if (!tok_i.have_match) begin
      if (!valid_q) begin
        if (!tok_i.have_free) begin
          tok_d.have_free = 1'b1;
          tok_d.free_slot = idx_i;
        end
      end else if (addr_q == tok_i.addr) begin
        tok_d.have_match  = 1'b1;
        tok_d.match_slot  = idx_i;
        tok_d.match_wtime = wtime_q;
      end else if (!tok_i.have_old || (seen_q < tok_i.old_time)) begin
        tok_d.have_old = 1'b1;
        tok_d.old_time = seen_q;
        tok_d.old_slot = idx_i;
      end
    end
  end

  // Token stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_vld_i) begin
      tok_q <= tok_d;
    end
  end

  // Entry valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (hit && wr_i.full) begin
      valid_q <= 1'b1;
    end
  end

  // Entry payload: full rewrite or refresh
  always_ff @(posedge clk_i) begin
    if (hit) begin
      sig_q  <= wr_i.sig;
      seen_q <= wr_i.now;
      if (wr_i.full) begin
        addr_q  <= wr_i.addr;
        pwr_q   <= wr_i.pwr;
        wtime_q <= wr_i.now;
        tgt_q   <= wr_i.tgt;
      end else if (wr_i.pwr != '0) begin
        pwr_q <= wr_i.pwr;
      end
    end
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_o     = tok_q;

endmodule

>>> design/seen_device_table_lru_core.sv
// ----------------------------------------------------------------------------
// seen_device_table_lru_core: seen-device table with least-recently-seen
// eviction
// Records advertisements in a table of TABLE_ENTRIES entries held in a row
// of cells and returns, per advertisement, the slot touched and the action.
// ----------------------------------------------------------------------------
// Each advertisement sends a search token down the row of table cells, one
// cell per cycle. An item passes through the walk through the cells, a
// registered decision and a finish step that writes the chosen entry and
// loads the result register. With discovery off an item goes straight to
// the finish step and the table is untouched. The result register lets the
// next advertisement be accepted while a result still waits to be taken; an
// item finishes only once that register is free.
// Entry valid bits clear at reset, so the table needs no clearing pass.
// Configuration writes are always accepted and are meant for idle periods.
// ----------------------------------------------------------------------------
module seen_device_table_lru_core import sdt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  sdt_adv_if.sink   adv,
  sdt_res_if.source res,
  sdt_cfg_if.sink   cfg
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_q, state_d;

  // Configuration registers
  logic [TIME_W-1:0] interval_q;
  logic              discover_q;

  // Current item
  logic [ADDR_W-1:0]       addr_q;
  logic signed [DBM_W-1:0] sig_q;
  logic signed [DBM_W-1:0] pwr_q;
  logic [TIME_W-1:0]       now_q;
  logic                    tgt_q;

  // Decision
  logic [IDX_W-1:0]    slot_q, slot_d;
  logic [ACTION_W-1:0] action_q, action_d;

  // Result register
  logic                out_vld_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [ACTION_W-1:0] out_action_q;

  logic    in_acc, out_acc, finish;
  logic    tok_vld [TABLE_ENTRIES+1];
  token_t  tok     [TABLE_ENTRIES+1];
  wr_cmd_t wr_cmd;
  logic [TIME_W-1:0] age;
  token_t  last;

  assign adv.ready = (state_q == ST_IDLE);
  assign in_acc    = adv.valid && adv.ready;
  assign out_acc   = res.valid && res.ready;
  assign finish    = (state_q == ST_FINISH) && (!out_vld_q || res.ready);
  assign cfg.ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= MIN_INTERVAL_RST;
      discover_q <= DISCOVER_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_MIN_INTERVAL: interval_q <= cfg.data[TIME_W-1:0];
        CFG_DISCOVER:     discover_q <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Token launch into the first cell
  assign tok_vld[0]         = in_acc && discover_q;
  assign tok[0].addr        = adv.device_addr;
  assign tok[0].have_free   = 1'b0;
  assign tok[0].free_slot   = '0;
  assign tok[0].have_old    = 1'b0;
  assign tok[0].old_time    = '0;
  assign tok[0].old_slot    = '0;
  assign tok[0].have_match  = 1'b0;
  assign tok[0].match_slot  = '0;
  assign tok[0].match_wtime = '0;

  // Row of table cells
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    sdt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (IDX_W'(g)),
      .tok_vld_i (tok_vld[g]),
      .tok_i     (tok[g]),
      .tok_vld_o (tok_vld[g+1]),
      .tok_o     (tok[g+1]),
      .wr_i      (wr_cmd)
    );
  end

  // Decision from the token leaving the last cell
  assign last = tok[TABLE_ENTRIES];
  assign age  = now_q - last.match_wtime;

  always_comb begin
    slot_d   = last.old_slot;
    action_d = ACT_EVICT;
    if (last.have_match) begin
      slot_d   = last.match_slot;
      action_d = (age < interval_q) ? ACT_REFRESH : ACT_REWRITE;
    end else if (last.have_free) begin
      slot_d   = last.free_slot;
      action_d = ACT_NEW;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_acc) state_d = discover_q ? ST_SEARCH : ST_FINISH;
      ST_SEARCH: if (tok_vld[TABLE_ENTRIES]) state_d = ST_FINISH;
      ST_FINISH: if (finish) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Item and decision registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      addr_q   <= adv.device_addr;
      sig_q    <= adv.signal_dbm;
      pwr_q    <= adv.ref_power_dbm;
      now_q    <= adv.time_ms;
      tgt_q    <= adv.target_flag;
      slot_q   <= '0;
      action_q <= ACT_SKIP;
    end else if ((state_q == ST_SEARCH) && tok_vld[TABLE_ENTRIES]) begin
      slot_q   <= slot_d;
      action_q <= action_d;
    end
  end

  // Write command to the cells
  assign wr_cmd.en   = finish && (action_q != ACT_SKIP);
  assign wr_cmd.full = (action_q != ACT_REFRESH);
  assign wr_cmd.slot = slot_q;
  assign wr_cmd.addr = addr_q;
  assign wr_cmd.sig  = sig_q;
  assign wr_cmd.pwr  = pwr_q;
  assign wr_cmd.now  = now_q;
  assign wr_cmd.tgt  = tgt_q;

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (finish) begin
      out_vld_q <= 1'b1;
    end else if (out_acc) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_slot_q   <= SLOT_W'(slot_q);
      out_action_q <= action_q;
    end
  end

  assign res.valid      = out_vld_q;
  assign res.slot_index = out_slot_q;
  assign res.action     = out_action_q;

endmodule

>>> verif/seen_device_table_lru_core_tb.sv
// ----------------------------------------------------------------------------
// seen_device_table_lru_core_tb: self-checking bench for the seen-device table
// Streams advertisements through the table under several register settings,
// keeps its own copy of the table to predict the slot and action of every
// result, and compares each result transaction against that prediction.
// ----------------------------------------------------------------------------
module seen_device_table_lru_core_tb;
  import sdt_pkg::*;

  localparam int TICK_LIMIT   = 3000;  // cycles with no transaction before giving up
  localparam int SETTLE_TICKS = 40;    // cycles waited once every item is answered
  localparam int POOL_N       = 48;
  localparam int HOLD_TICKS   = 400;

  typedef struct {
    logic [ADDR_W-1:0]       addr;
    logic signed [DBM_W-1:0] sig;
    logic signed [DBM_W-1:0] pwr;
    logic [TIME_W-1:0]       now;
    logic                    tgt;
  } adv_item_t;

  typedef struct {
    logic [SLOT_W-1:0]   slot;
    logic [ACTION_W-1:0] action;
  } slot_report_t;

  logic clk_i;
  logic rst_ni;

  sdt_adv_if adv ();
  sdt_res_if res ();
  sdt_cfg_if cfg ();

  seen_device_table_lru_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv    (adv),
    .res    (res),
    .cfg    (cfg)
  );

  // Shadow table: only what decides slot and action is kept
  logic              tbl_valid [TABLE_ENTRIES];
  logic [ADDR_W-1:0] tbl_addr  [TABLE_ENTRIES];
  logic [TIME_W-1:0] tbl_seen  [TABLE_ENTRIES];
  logic [TIME_W-1:0] tbl_wtime [TABLE_ENTRIES];
  logic [TIME_W-1:0] min_interval;
  logic              discover_on;

  adv_item_t    adv_backlog[$];
  slot_report_t predicted_slot_q[$];
  adv_item_t    cur_adv;
  slot_report_t got_report;

  logic [ADDR_W-1:0] addr_pool [POOL_N];
  logic [TIME_W-1:0] now_ms;

  int  queued_cnt;
  int  sent_cnt;
  int  err_cnt;
  int  reg_writes;
  int  idle_ticks;
  int  hold_left;
  int  act_seen [8];
  bit  gaps_on;
  bit  pressure_req;

  // Apply one sighting to the shadow table and return the slot and action
  function automatic slot_report_t track_sighting(input adv_item_t it);
    slot_report_t      r;
    bit                hit;
    bit                got_free;
    bit                got_old;
    int                hit_i;
    int                free_i;
    int                old_i;
    int                slot;
    logic [TIME_W-1:0] old_t;
    logic [TIME_W-1:0] age;
    r.slot   = '0;
    r.action = ACT_SKIP;
    hit      = 1'b0;
    got_free = 1'b0;
    got_old  = 1'b0;
    hit_i    = 0;
    free_i   = 0;
    old_i    = 0;
    old_t    = '0;
    if (!discover_on) return r;

    // walk: first free slot, address match, least recently seen (lowest wins ties)
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!tbl_valid[i]) begin
        if (!got_free) begin
          got_free = 1'b1;
          free_i   = i;
        end
      end else if (tbl_addr[i] == it.addr) begin
        hit   = 1'b1;
        hit_i = i;
        break;
      end else if (!got_old || tbl_seen[i] < old_t) begin
        got_old = 1'b1;
        old_t   = tbl_seen[i];
        old_i   = i;
      end
    end

    if (hit) begin
      // age wraps modulo 2^32
      age = it.now - tbl_wtime[hit_i];
      if (age < min_interval) begin
        tbl_seen[hit_i] = it.now;
        r.slot   = SLOT_W'(hit_i);
        r.action = ACT_REFRESH;
        return r;
      end
      slot     = hit_i;
      r.action = ACT_REWRITE;
    end else if (got_free) begin
      slot     = free_i;
      r.action = ACT_NEW;
    end else begin
      slot     = got_old ? old_i : 0;
      r.action = ACT_EVICT;
    end

    tbl_valid[slot] = 1'b1;
    tbl_addr[slot]  = it.addr;
    tbl_seen[slot]  = it.now;
    tbl_wtime[slot] = it.now;
    r.slot = SLOT_W'(slot);
    return r;
  endfunction

  // Random advertisement: mostly pooled addresses on a drifting clock
  function automatic adv_item_t rand_adv(input int pool_n);
    adv_item_t it;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 85) it.addr = addr_pool[$urandom_range(pool_n - 1)];
    else           it.addr = {16'($urandom), 32'($urandom)};
    pick = $urandom_range(99);
    // same ms gives seen-time ties; a jump can go backwards or wrap
    if (pick < 25)      now_ms = now_ms;
    else if (pick < 90) now_ms = now_ms + TIME_W'($urandom_range(1, 700));
    else                now_ms = $urandom;
    it.now = now_ms;
    it.sig = DBM_W'($urandom);
    it.pwr = ($urandom_range(99) < 40) ? '0 : DBM_W'($urandom);
    it.tgt = 1'($urandom);
    return it;
  endfunction

  task automatic queue_adv(input adv_item_t it);
    adv_backlog.push_back(it);
    queued_cnt++;
  endtask

  task automatic queue_fields(input logic [ADDR_W-1:0] addr, input logic signed [DBM_W-1:0] sig,
                              input logic signed [DBM_W-1:0] pwr, input logic [TIME_W-1:0] t,
                              input logic tgt);
    adv_item_t it;
    it.addr = addr;
    it.sig  = sig;
    it.pwr  = pwr;
    it.now  = t;
    it.tgt  = tgt;
    queue_adv(it);
  endtask

  // Wait until every queued item has been taken and answered, then let the block settle
  task automatic wait_table_idle();
    do @(posedge clk_i); while (sent_cnt != queued_cnt || predicted_slot_q.size() != 0);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  // One register write transaction; the shadow copy follows on acceptance
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == CFG_MIN_INTERVAL) min_interval = val[TIME_W-1:0];
    else if (idx == CFG_DISCOVER) discover_on = val[0];
    reg_writes++;
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Advertisement driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adv.valid         <= 1'b0;
      adv.device_addr   <= '0;
      adv.signal_dbm    <= '0;
      adv.ref_power_dbm <= '0;
      adv.time_ms       <= '0;
      adv.target_flag   <= 1'b0;
    end else begin
      if (adv.valid && adv.ready) begin
        predicted_slot_q.push_back(track_sighting(cur_adv));
        sent_cnt++;
      end
      if (!adv.valid || adv.ready) begin
        if (adv_backlog.size() != 0 && !(gaps_on && $urandom_range(99) < 33)) begin
          cur_adv            = adv_backlog.pop_front();
          adv.valid         <= 1'b1;
          adv.device_addr   <= cur_adv.addr;
          adv.signal_dbm    <= cur_adv.sig;
          adv.ref_power_dbm <= cur_adv.pwr;
          adv.time_ms       <= cur_adv.now;
          adv.target_flag   <= cur_adv.tgt;
        end else begin
          adv.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
      hold_left  = 0;
    end else begin
      if (res.valid && res.ready) begin
        act_seen[res.action]++;
        if (predicted_slot_q.size() == 0) begin
          $error("result transaction with nothing expected: slot %0d action %0d",
                 res.slot_index, res.action);
          err_cnt++;
        end else begin
          got_report = predicted_slot_q.pop_front();
          if (res.slot_index !== got_report.slot) begin
            $error("slot_index mismatch: expected %0d, actual %0d",
                   got_report.slot, res.slot_index);
            err_cnt++;
          end
          if (res.action !== got_report.action) begin
            $error("action mismatch: expected %0d, actual %0d", got_report.action, res.action);
            err_cnt++;
          end
        end
      end
      if (pressure_req) begin
        pressure_req = 1'b0;
        hold_left    = HOLD_TICKS;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= !(gaps_on && $urandom_range(99) < 33);
      end
    end
  end

  // Watchdog on transaction activity
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((adv.valid && adv.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)) begin
        idle_ticks = 0;
      end else begin
        idle_ticks++;
        if (idle_ticks >= TICK_LIMIT) begin
          $display("seen_device_table_lru_core verification failed");
          $finish;
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    rst_ni       = 1'b0;
    adv.valid    = 1'b0;
    res.ready    = 1'b0;
    cfg.valid    = 1'b0;
    cfg.index    = '0;
    cfg.data     = '0;
    gaps_on      = 1'b1;
    pressure_req = 1'b0;
    queued_cnt   = 0;
    sent_cnt     = 0;
    err_cnt      = 0;
    reg_writes   = 0;
    idle_ticks   = 0;
    min_interval = MIN_INTERVAL_RST;
    discover_on  = DISCOVER_RST;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    foreach (act_seen[i]) act_seen[i] = 0;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < POOL_N; i++) addr_pool[i] = {16'($urandom), 32'($urandom)};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset settings, field extremes, refresh/rewrite boundaries, wrapped age
    queue_fields('0, -8'sd128, 8'sd0, 32'd0, 1'b0);                // new slot
    queue_fields('1, 8'sd127, 8'sd127, 32'hFFFF_FFFF, 1'b1);      // new slot
    queue_fields('0, 8'sd0, 8'sd0, 32'd10, 1'b0);                 // refresh, power kept
    queue_fields('0, -8'sd1, -8'sd128, 32'd999, 1'b1);            // refresh just inside interval
    queue_fields('0, 8'sd3, 8'sd0, 32'd1000, 1'b0);               // age equals interval: rewrite
    queue_fields('1, 8'sd20, 8'sd0, 32'd100, 1'b0);               // age across wrap: refresh
    queue_fields('0, 8'sd4, 8'sd5, 32'd500, 1'b1);                // time went back: rewrite
    queue_fields(48'h5555_5555_5555, 8'sd85, 8'sd85, 32'd0, 1'b0);
    queue_fields(48'hAAAA_AAAA_AAAA, -8'sd86, -8'sd86, 32'd0, 1'b1);
    queue_fields(48'h0000_0000_0001, 8'sd1, 8'sd1, 32'h8000_0000, 1'b0);
    queue_fields(48'h8000_0000_0000, -8'sd2, 8'sd0, 32'h7FFF_FFFF, 1'b1);
    wait_table_idle();

    // Interval zero: every match is rewritten
    write_reg(CFG_MIN_INTERVAL, 32'd0);
    queue_fields('0, 8'sd7, 8'sd0, 32'd500, 1'b0);
    now_ms = 32'd20000;
    repeat (180) queue_adv(rand_adv(POOL_N));
    wait_table_idle();

    // Largest interval: matches refresh unless the age is all ones
    write_reg(CFG_MIN_INTERVAL, 32'hFFFF_FFFF);
    queue_fields('1, 8'sd9, 8'sd0, 32'hFFFF_FFFE, 1'b1);
    repeat (180) queue_adv(rand_adv(POOL_N));
    wait_table_idle();

    // Discovery off: table untouched, every result skipped
    write_reg(CFG_DISCOVER, 32'd0);
    repeat (60) queue_adv(rand_adv(POOL_N));
    wait_table_idle();
    write_reg(CFG_DISCOVER, 32'd1);

    // Mid interval, small address set, no gaps on either side
    write_reg(CFG_MIN_INTERVAL, 32'($urandom_range(500, 5000)));
    gaps_on = 1'b0;
    repeat (240) queue_adv(rand_adv(12));
    wait_table_idle();
    gaps_on = 1'b1;

    // Back to the reset interval; receiver holds off so the input backs up
    write_reg(CFG_MIN_INTERVAL, 32'(MIN_INTERVAL_RST));
    repeat (240) queue_adv(rand_adv(POOL_N));
    pressure_req = 1'b1;
    wait_table_idle();

    $display("Run: %0d advertisements under %0d register writes, incl. a %0d-cycle output stall",
             sent_cnt, reg_writes, HOLD_TICKS);
    $display("Actions seen: skip %0d refresh %0d rewrite %0d new %0d evict %0d",
             act_seen[ACT_SKIP], act_seen[ACT_REFRESH], act_seen[ACT_REWRITE],
             act_seen[ACT_NEW], act_seen[ACT_EVICT]);
    if (err_cnt == 0) begin
      $display("seen_device_table_lru_core verification clean");
    end else begin
      $display("seen_device_table_lru_core verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/sdt_pkg.sv
design/sdt_if.sv
design/sdt_cell.sv
design/seen_device_table_lru_core.sv
verif/seen_device_table_lru_core_tb.sv
